[rtl/rmq_pkg.sv]
// Shared types and constants for the rotation matrix to quaternion core.
// Used by rmq_udiv_pipe and rotation_matrix_to_quaternion_core.
package rmq_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int ELEM_W     = 16;
    localparam int NUM_ELEMS  = 9;
    localparam int VAL_W      = ELEM_W + 2;
    localparam int PAIR_W     = ELEM_W + 1;
    localparam int ROOT_STEPS = 16;
    localparam int QUO_BITS   = 16;
    localparam int WORD_W     = 32;
    localparam int BEST_W     = 16;
    localparam int DEN_W      = BEST_W + 2;

    typedef enum logic [1:0] {
        COMP_W = 2'd0,
        COMP_X = 2'd1,
        COMP_Y = 2'd2,
        COMP_Z = 2'd3
    } comp_t;

    // Item sideband through the root stages.
    typedef struct packed {
        comp_t                   idx;
        logic [3:0]              neg;
        logic [3:0][PAIR_W-1:0]  mag;
    } root_side_t;

    // Item sideband through the divider stages.
    typedef struct packed {
        comp_t             idx;
        logic [3:0]        neg;
        logic [BEST_W-1:0] best;
    } div_side_t;

endpackage

[rtl/rmq_udiv_pipe.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on rmq_pkg; quotient must fit in QUO_BITS bits.
module rmq_udiv_pipe
    import rmq_pkg::*;
(
    input  logic                aclk,
    input  logic                en,
    input  logic [WORD_W-1:0]   num_in,
    input  logic [DEN_W-1:0]    den_in,
    output logic [QUO_BITS-1:0] quo_out
);

    logic [WORD_W-1:0]   n_reg [QUO_BITS];
    logic [DEN_W-1:0]    d_reg [QUO_BITS];
    logic [QUO_BITS-1:0] q_reg [QUO_BITS];

    genvar k;
    generate
        for (k = 0; k < QUO_BITS; k++) begin : g_step
            logic [WORD_W-1:0]   n_in;
            logic [DEN_W-1:0]    d_in;
            logic [QUO_BITS-1:0] q_in;
            logic [WORD_W-1:0]   sh;
            logic                ge;
            logic [WORD_W-1:0]   n_next;
            logic [QUO_BITS-1:0] q_next;

            if (k == 0) begin : g_first
                assign n_in = num_in;
                assign d_in = den_in;
                assign q_in = '0;
            end else begin : g_rest
                assign n_in = n_reg[k-1];
                assign d_in = d_reg[k-1];
                assign q_in = q_reg[k-1];
            end

            // Try the divisor at this quotient weight
            assign sh     = WORD_W'(d_in) << (QUO_BITS - 1 - k);
            assign ge     = (n_in >= sh);
            assign n_next = ge ? (n_in - sh) : n_in;
            assign q_next = q_in | (QUO_BITS'(ge) << (QUO_BITS - 1 - k));

            always_ff @(posedge aclk) begin
                if (en) begin
                    n_reg[k] <= n_next;
                    d_reg[k] <= d_in;
                    q_reg[k] <= q_next;
                end
            end
        end
    endgenerate

    assign quo_out = q_reg[QUO_BITS-1];

endmodule

[rtl/rotation_matrix_to_quaternion_core.sv]
// Top level of the rotation matrix to quaternion core.
// Depends on rmq_pkg and rmq_udiv_pipe.
//
// Usage:
//   s_ channel: one 3x3 matrix per item, nine signed Q2.14 elements in
//   s_tdata, row-major, row 0 column 0 in the lowest 16 bits.
//   m_ channel: one quaternion per item, x, y, z, w in m_tdata from the
//   lowest bits up, and the index of the largest component in m_tuser.
//   From acceptance to m_tvalid an item passes the diagonal sums stage, the
//   selection stage, ROOT_STEPS bit-per-stage square root stages, a stage
//   that forms numerators, QUO_BITS bit-per-stage divider stages (four
//   dividers in parallel) and one output register.
//   One item per cycle unless the output stalls; every stage holds one item.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and s_tready drops; empty stages do not advance either, so no
//   item is lost or repeated.
//   Reset clears all valid bits; payload registers are not reset.
module rotation_matrix_to_quaternion_core
    import rmq_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1,
                                    // m_r1c2, m_r2c0, m_r2c1, m_r2c2
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // q_x, q_y, q_z, q_w
    output logic [1:0]   m_tuser    // largest_component
);

    localparam logic [VAL_W-1:0] ONE_VAL = VAL_W'(1) << FRAC_BITS;

    logic en;

    // ---------------- stage 1: diagonal values and pair sums
    logic signed [ELEM_W-1:0] e [NUM_ELEMS];
    logic signed [VAL_W-1:0]  val_next [4];
    logic signed [PAIR_W-1:0] pair_next [6];
    logic signed [VAL_W-1:0]  val_reg [4];
    logic signed [PAIR_W-1:0] pair_reg [6];
    logic                     v1_reg;

    always_comb begin
        for (int i = 0; i < NUM_ELEMS; i++) begin
            e[i] = $signed(s_tdata[ELEM_W*i +: ELEM_W]);
        end
        val_next[0] = VAL_W'(e[0]) + VAL_W'(e[4]) + VAL_W'(e[8]);
        val_next[1] = VAL_W'(e[0]) - VAL_W'(e[4]) - VAL_W'(e[8]);
        val_next[2] = VAL_W'(e[4]) - VAL_W'(e[0]) - VAL_W'(e[8]);
        val_next[3] = VAL_W'(e[8]) - VAL_W'(e[0]) - VAL_W'(e[4]);
        // Working matrix is the transpose of the passed one
        pair_next[0] = PAIR_W'(e[7]) - PAIR_W'(e[5]);
        pair_next[1] = PAIR_W'(e[2]) - PAIR_W'(e[6]);
        pair_next[2] = PAIR_W'(e[3]) - PAIR_W'(e[1]);
        pair_next[3] = PAIR_W'(e[3]) + PAIR_W'(e[1]);
        pair_next[4] = PAIR_W'(e[2]) + PAIR_W'(e[6]);
        pair_next[5] = PAIR_W'(e[7]) + PAIR_W'(e[5]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg  <= val_next;
            pair_reg <= pair_next;
        end
    end

    // ---------------- stage 2: pick largest, root operand, slot numerators
    comp_t                   idx_sel;
    logic signed [VAL_W-1:0] arg_val;
    logic signed [PAIR_W-1:0] slot_d [4];
    root_side_t              side2_next;
    logic [WORD_W-1:0]       x2_next;
    logic [WORD_W-1:0]       x2_reg;
    root_side_t              side2_reg;
    logic                    v2_reg;

    always_comb begin
        idx_sel = COMP_W;
        for (int i = 1; i < 4; i++) begin
            if (val_reg[i] > val_reg[idx_sel]) begin
                idx_sel = comp_t'(i[1:0]);
            end
        end
        arg_val = val_reg[idx_sel] + ONE_VAL;
        x2_next = WORD_W'(unsigned'(arg_val[VAL_W-2:0])) << FRAC_BITS;

        unique case (idx_sel)
            COMP_W: begin
                slot_d[0] = '0;          slot_d[1] = pair_reg[0];
                slot_d[2] = pair_reg[1]; slot_d[3] = pair_reg[2];
            end
            COMP_X: begin
                slot_d[0] = pair_reg[0]; slot_d[1] = '0;
                slot_d[2] = pair_reg[3]; slot_d[3] = pair_reg[4];
            end
            COMP_Y: begin
                slot_d[0] = pair_reg[1]; slot_d[1] = pair_reg[3];
                slot_d[2] = '0;          slot_d[3] = pair_reg[5];
            end
            default: begin
                slot_d[0] = pair_reg[2]; slot_d[1] = pair_reg[4];
                slot_d[2] = pair_reg[5]; slot_d[3] = '0;
            end
        endcase

        side2_next.idx = idx_sel;
        for (int n = 0; n < 4; n++) begin
            side2_next.neg[n] = slot_d[n][PAIR_W-1];
            side2_next.mag[n] = slot_d[n][PAIR_W-1] ? PAIR_W'(-slot_d[n])
                                                    : PAIR_W'(slot_d[n]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x2_reg    <= x2_next;
            side2_reg <= side2_next;
        end
    end

    // ---------------- root stages: one result bit per stage
    logic [WORD_W-1:0] sq_x_reg    [ROOT_STEPS];
    logic [WORD_W-1:0] sq_r_reg    [ROOT_STEPS];
    root_side_t        sq_side_reg [ROOT_STEPS];
    logic [ROOT_STEPS-1:0] sq_v_reg;

    genvar k;
    generate
        for (k = 0; k < ROOT_STEPS; k++) begin : g_root
            localparam logic [WORD_W-1:0] BIT = WORD_W'(1) << (2*(ROOT_STEPS-1-k));
            logic [WORD_W-1:0] x_in;
            logic [WORD_W-1:0] r_in;
            root_side_t        s_in;
            logic [WORD_W-1:0] t;
            logic [WORD_W-1:0] x_next;
            logic [WORD_W-1:0] r_next;

            if (k == 0) begin : g_first
                assign x_in = x2_reg;
                assign r_in = '0;
                assign s_in = side2_reg;
            end else begin : g_rest
                assign x_in = sq_x_reg[k-1];
                assign r_in = sq_r_reg[k-1];
                assign s_in = sq_side_reg[k-1];
            end

            always_comb begin
                t = r_in + BIT;
                if (x_in >= t) begin
                    x_next = x_in - t;
                    r_next = (r_in >> 1) + BIT;
                end else begin
                    x_next = x_in;
                    r_next = r_in >> 1;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    sq_x_reg[k]    <= x_next;
                    sq_r_reg[k]    <= r_next;
                    sq_side_reg[k] <= s_in;
                end
            end
        end
    endgenerate

    // ---------------- prep stage: numerators with half-divisor rounding
    logic [BEST_W-1:0]    best_w;
    logic [WORD_W-1:0]    num_next [4];
    logic [WORD_W-1:0]    num_reg  [4];
    logic [DEN_W-1:0]     den_reg;
    div_side_t            pside_reg;
    logic                 vp_reg;

    assign best_w = sq_r_reg[ROOT_STEPS-1][BEST_W:1];

    always_comb begin
        for (int n = 0; n < 4; n++) begin
            num_next[n] = (WORD_W'(sq_side_reg[ROOT_STEPS-1].mag[n]) << FRAC_BITS)
                        + (WORD_W'(best_w) << 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg        <= num_next;
            den_reg        <= DEN_W'(best_w) << 2;
            pside_reg.idx  <= sq_side_reg[ROOT_STEPS-1].idx;
            pside_reg.neg  <= sq_side_reg[ROOT_STEPS-1].neg;
            pside_reg.best <= best_w;
        end
    end

    // ---------------- divider stages
    logic [QUO_BITS-1:0] quo [4];
    div_side_t           dv_side_reg [QUO_BITS];
    logic [QUO_BITS-1:0] dv_v_reg;

    genvar n;
    generate
        for (n = 0; n < 4; n++) begin : g_div
            rmq_udiv_pipe u_div (
                .aclk    (aclk),
                .en      (en),
                .num_in  (num_reg[n]),
                .den_in  (den_reg),
                .quo_out (quo[n])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_side_reg[0] <= pside_reg;
            for (int i = 1; i < QUO_BITS; i++) begin
                dv_side_reg[i] <= dv_side_reg[i-1];
            end
        end
    end

    // ---------------- output stage: sign, saturate, order x y z w
    localparam logic [QUO_BITS-1:0] POS_MAX = {1'b0, {(QUO_BITS-1){1'b1}}};
    localparam logic [QUO_BITS-1:0] NEG_MAG = {1'b1, {(QUO_BITS-1){1'b0}}};

    div_side_t           dfin;
    logic [ELEM_W-1:0]   comp_next [4];
    logic [63:0]         tdata_next;
    logic [63:0]         tdata_reg;
    logic [1:0]          tuser_reg;
    logic                out_v_reg;

    assign dfin = dv_side_reg[QUO_BITS-1];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (dfin.idx == comp_t'(i[1:0])) begin
                comp_next[i] = ELEM_W'(dfin.best);
            end else if (dfin.neg[i]) begin
                comp_next[i] = (quo[i] > NEG_MAG) ? NEG_MAG : ELEM_W'(-quo[i]);
            end else begin
                comp_next[i] = (quo[i] > POS_MAX) ? POS_MAX : ELEM_W'(quo[i]);
            end
        end
        tdata_next = {comp_next[0], comp_next[3], comp_next[2], comp_next[1]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tdata_reg <= tdata_next;
            tuser_reg <= dfin.idx;
        end
    end

    // ---------------- valid bits and flow control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            sq_v_reg  <= '0;
            vp_reg    <= 1'b0;
            dv_v_reg  <= '0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            sq_v_reg  <= {sq_v_reg[ROOT_STEPS-2:0], v2_reg};
            vp_reg    <= sq_v_reg[ROOT_STEPS-1];
            dv_v_reg  <= {dv_v_reg[QUO_BITS-2:0], vp_reg};
            out_v_reg <= dv_v_reg[QUO_BITS-1];
        end
    end

    // Advance everything unless a finished item waits at the output
    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

`ifndef SYNTHESIS
    // Largest value is never negative, so the root operand is at least one
    a_arg_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (x2_reg >= (WORD_W'(1) << (2*FRAC_BITS))))
        else $error("root operand below one");

    // Divisor is at least 4 * 2^(FRAC_BITS-1)
    a_den_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        vp_reg |-> (den_reg >= (DEN_W'(1) << (FRAC_BITS+1))))
        else $error("divisor below floor");

    // Winning component is the root term, at least one half
    a_best_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[ELEM_W*((32'(m_tuser) + 3) % 4) +: ELEM_W]
                      >= (ELEM_W'(1) << (FRAC_BITS-1))))
        else $error("largest component below one half");

    // A held output freezes the input side
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(sq_r_reg[0]) && $stable(x2_reg))
        else $error("pipeline moved during stall");
`endif

endmodule
